/* rtl/ngram_backoff_transition_lookup_defines.svh */
// Assertion macros shared by the checker of the n-gram backoff lookup.
// No dependencies; included by the files that assert.
`ifndef NGRAM_BACKOFF_TRANSITION_LOOKUP_DEFINES_SVH
`define NGRAM_BACKOFF_TRANSITION_LOOKUP_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define NBTL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when the trigger holds, the consequence must hold in the next cycle.
`define NBTL_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/nbtl_pkg.sv */
// Package of the n-gram backoff lookup: payload types, codes and the saturating
// log-domain adder. No dependencies.
package nbtl_pkg;

	localparam int MAX_STATES_DEF      = 4096;
	localparam int MAX_TRANSITIONS_DEF = 65536;
	localparam int MAX_GROUPS_DEF      = 16;
	localparam int VOCAB_DEF           = 65536;

	// Width of a linear scan slot: (13-bit state offset * 16-bit fan) + 17-bit index.
	localparam int LIN_W = 31;

	localparam logic signed [23:0] SCORE_MIN = 24'sh800000;
	localparam logic signed [23:0] SCORE_MAX = 24'sh7FFFFF;

	typedef enum logic [2:0] {
		CMD_QUERY   = 3'd0,
		CMD_WALK    = 3'd1,
		CMD_WR_TRAN = 3'd2,
		CMD_WR_GRP  = 3'd3,
		CMD_WR_FIRST = 3'd4,
		CMD_WR_BO   = 3'd5,
		CMD_RSVD6   = 3'd6,
		CMD_RSVD7   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_WRITE_ACK = 2'd2,
		ST_UNUSED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LOWEST       = 2'd0,
		REG_BINARY_FIRST = 2'd1,
		REG_GROUP_COUNT  = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [15:0]        entry_index;
		logic [15:0]        word;
		logic [11:0]        query_state;
		logic signed [23:0] log_score;
		logic [12:0]        group_first_state;
		logic [15:0]        group_fan_out;
		logic [16:0]        first_transition_index;
		logic               walk_start;
	} item_t;

	typedef struct packed {
		logic [11:0]        dest_state;
		logic signed [23:0] result_score;
		logic [1:0]         status;
	} result_t;

	// Log-domain product: zero probability absorbs, the sum saturates.
	function automatic logic signed [23:0] log_add(input logic signed [23:0] a,
		input logic signed [23:0] b);
		logic signed [24:0] s;
		s = 25'(a) + 25'(b);
		if (a == SCORE_MIN || b == SCORE_MIN) begin
			return SCORE_MIN;
		end else if (s < 25'(SCORE_MIN)) begin
			return SCORE_MIN;
		end else if (s > 25'(SCORE_MAX)) begin
			return SCORE_MAX;
		end
		return s[23:0];
	endfunction

endpackage

/* rtl/ngram_backoff_transition_lookup.sv */
// Top level of the n-gram backoff lookup: command sequencer, table memories
// and the shared log-domain adder. Depends on nbtl_pkg and nbtl_ram.
//
// A command is taken when start is high and busy is low; its one result word
// appears on result for a single cycle with done high and cannot be held off.
// Table writes and walk steps with word 0 answer in the cycle after acceptance.
// A lookup visits states one after another and searches each: a linear group
// state reads the group headers in turn, multiplies the offset by the fan, adds
// the first index and then compares transitions one by one; a binary state reads
// its range and then probes it; a search that runs out of headers, transitions
// or range ends with a final bound check; each backoff hop reads the backoff
// table.
// Every table sits in one read-port memory, and that single port per table
// sets the pace of the search. No clearing pass is run after reset.
module ngram_backoff_transition_lookup #(
	parameter int MAX_STATES      = nbtl_pkg::MAX_STATES_DEF,
	parameter int MAX_TRANSITIONS = nbtl_pkg::MAX_TRANSITIONS_DEF,
	parameter int MAX_GROUPS      = nbtl_pkg::MAX_GROUPS_DEF,
	parameter int VOCAB           = nbtl_pkg::VOCAB_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  nbtl_pkg::item_t  item,
	output logic             done,
	output nbtl_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [12:0]      cfg_data
);
	import nbtl_pkg::*;

	localparam int TA = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int SA = $clog2(MAX_STATES + 1);
	localparam int BA = $clog2(MAX_STATES);
	localparam int GA = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GW = $clog2(MAX_GROUPS + 1) > 5 ? $clog2(MAX_GROUPS + 1) : 5;
	localparam int VW = $clog2(MAX_STATES + 1);
	localparam logic [31:0] MAX_ST_L = 32'(MAX_STATES);
	localparam logic [31:0] MAX_TR_L = 32'(MAX_TRANSITIONS);
	localparam logic [31:0] MAX_GR_L = 32'(MAX_GROUPS);
	localparam logic [31:0] VOCAB_L  = 32'(VOCAB);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_GRP_RD, S_GRP_CHK, S_LIN_MUL, S_LIN_ADD, S_LIN_RD,
		S_LIN_CHK, S_SF_RD0, S_SF_RD1, S_SF_CHK, S_BIN_RD, S_BIN_CHK, S_MISS,
		S_BO_RD, S_BO_CHK
	} state_t;

	state_t state_q;

	logic [11:0]        lowest_q;
	logic [12:0]        bin_first_q;
	logic [4:0]         grp_cnt_q;
	logic [11:0]        walk_q;
	logic               is_walk_q;
	logic [15:0]        w_q;
	logic [11:0]        st_q;
	logic signed [23:0] accum_q;
	logic [VW-1:0]      visits_q;
	logic [GW-1:0]      g_q;
	logic               cand_q;
	logic [12:0]        cand_st_q;
	logic [15:0]        cand_fan_q;
	logic [16:0]        cand_idx_q;
	logic [28:0]        prod_q;
	logic [LIN_W-1:0]   t_q;
	logic [LIN_W-1:0]   last_q;
	logic [16:0]        lo_q;
	logic [16:0]        hi_q;
	logic [17:0]        mid_q;
	logic               done_q;
	result_t            result_q;

	// Memory ports
	logic              tr_we, tr_re, gr_we, gr_re, sf_we, sf_re, bo_we, bo_re;
	logic [TA-1:0]     tr_raddr;
	logic [51:0]       tr_rdata;
	logic [GA-1:0]     gr_raddr;
	logic [45:0]       gr_rdata;
	logic [SA-1:0]     sf_raddr;
	logic [16:0]       sf_rdata;
	logic [BA-1:0]     bo_raddr;
	logic [35:0]       bo_rdata;

	logic              accept;
	cmd_t              cmd_in;
	logic [31:0]       idx32;
	logic [11:0]       start_st;
	logic [GW-1:0]     grp_lim;
	logic [17:0]       mid_c;
	logic [15:0]       tr_word;
	logic [11:0]       tr_dest;
	logic signed [23:0] tr_score;
	logic [12:0]       gr_state;
	logic [15:0]       gr_fan;
	logic [16:0]       gr_index;
	logic signed [23:0] bo_w;
	logic [11:0]       bo_d;
	logic signed [23:0] add_b;
	logic signed [23:0] add_sum;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign cmd_in    = cmd_t'(item.cmd);
	assign idx32     = 32'(item.entry_index);
	assign start_st  = item.walk_start ? lowest_q : walk_q;
	assign grp_lim   = (32'(grp_cnt_q) > MAX_GR_L) ? GW'(MAX_GROUPS) : GW'(grp_cnt_q);
	assign mid_c     = (18'(lo_q) + 18'(hi_q)) >> 1;

	assign {tr_word, tr_dest, tr_score}  = tr_rdata;
	assign {gr_state, gr_fan, gr_index}  = gr_rdata;
	assign {bo_w, bo_d}                  = bo_rdata;

	// The one score adder serves backoff accumulation and the final hit.
	assign add_b   = (state_q == S_BO_CHK) ? bo_w : tr_score;
	assign add_sum = log_add(accum_q, add_b);

	assign tr_we = accept && (cmd_in == CMD_WR_TRAN) && (idx32 < MAX_TR_L);
	assign gr_we = accept && (cmd_in == CMD_WR_GRP) && (idx32 < MAX_GR_L);
	assign sf_we = accept && (cmd_in == CMD_WR_FIRST) && (idx32 <= MAX_ST_L);
	assign bo_we = accept && (cmd_in == CMD_WR_BO) && (idx32 < MAX_ST_L);

	assign tr_re    = (state_q == S_LIN_RD) || (state_q == S_BIN_RD);
	assign tr_raddr = (state_q == S_BIN_RD) ? TA'(mid_c) : TA'(t_q);
	assign gr_re    = (state_q == S_GRP_RD);
	assign gr_raddr = GA'(g_q);
	assign sf_re    = (state_q == S_SF_RD0) || (state_q == S_SF_RD1);
	assign sf_raddr = (state_q == S_SF_RD1) ? SA'(st_q) + SA'(1) : SA'(st_q);
	assign bo_re    = (state_q == S_BO_RD);
	assign bo_raddr = BA'(st_q);

	nbtl_ram #(.WIDTH(52), .DEPTH(MAX_TRANSITIONS), .AW(TA)) u_trans (
		.clk, .we(tr_we), .waddr(TA'(item.entry_index)),
		.wdata({item.word, item.query_state, item.log_score}),
		.re(tr_re), .raddr(tr_raddr), .rdata(tr_rdata)
	);

	nbtl_ram #(.WIDTH(46), .DEPTH(MAX_GROUPS), .AW(GA)) u_groups (
		.clk, .we(gr_we), .waddr(GA'(item.entry_index)),
		.wdata({item.group_first_state, item.group_fan_out, item.first_transition_index}),
		.re(gr_re), .raddr(gr_raddr), .rdata(gr_rdata)
	);

	nbtl_ram #(.WIDTH(17), .DEPTH(MAX_STATES + 1), .AW(SA)) u_first (
		.clk, .we(sf_we), .waddr(SA'(item.entry_index)),
		.wdata(item.first_transition_index),
		.re(sf_re), .raddr(sf_raddr), .rdata(sf_rdata)
	);

	nbtl_ram #(.WIDTH(36), .DEPTH(MAX_STATES), .AW(BA)) u_backoff (
		.clk, .we(bo_we), .waddr(BA'(item.entry_index)),
		.wdata({item.log_score, item.query_state}),
		.re(bo_re), .raddr(bo_raddr), .rdata(bo_rdata)
	);

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lowest_q    <= '0;
			bin_first_q <= '0;
			grp_cnt_q   <= '0;
			walk_q      <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
			is_walk_q   <= 1'b0;
			w_q         <= '0;
			st_q        <= '0;
			accum_q     <= '0;
			visits_q    <= '0;
			g_q         <= '0;
			cand_q      <= 1'b0;
			cand_st_q   <= '0;
			cand_fan_q  <= '0;
			cand_idx_q  <= '0;
			prod_q      <= '0;
			t_q         <= '0;
			last_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_LOWEST:       lowest_q    <= cfg_data[11:0];
					REG_BINARY_FIRST: bin_first_q <= cfg_data;
					REG_GROUP_COUNT:  grp_cnt_q   <= cfg_data[4:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						is_walk_q <= (cmd_in == CMD_WALK);
						w_q       <= item.word;
						accum_q   <= '0;
						visits_q  <= '0;
						if (cmd_in == CMD_WALK && item.walk_start) begin
							walk_q <= lowest_q;
						end
						if (cmd_in == CMD_QUERY || cmd_in == CMD_WALK) begin
							st_q <= (cmd_in == CMD_WALK) ? start_st : item.query_state;
							if (cmd_in == CMD_WALK && item.word == '0) begin
								done_q   <= 1'b1;
								result_q <= '{start_st, 24'sd0, ST_FOUND};
							end else if (32'(item.word) >= VOCAB_L) begin
								done_q   <= 1'b1;
								result_q <= '{lowest_q, SCORE_MIN, ST_NOT_FOUND};
							end else begin
								state_q <= S_CHECK;
							end
						end else begin
							done_q   <= 1'b1;
							result_q <= '{12'd0, 24'sd0, ST_WRITE_ACK};
						end
					end
				end
				S_CHECK: begin
					// Visit limit also ends a backoff cycle.
					if (32'(visits_q) >= MAX_ST_L || 32'(st_q) >= MAX_ST_L) begin
						done_q   <= 1'b1;
						result_q <= '{lowest_q, SCORE_MIN, ST_NOT_FOUND};
						state_q  <= S_IDLE;
					end else if (13'(st_q) < bin_first_q) begin
						g_q     <= '0;
						cand_q  <= 1'b0;
						state_q <= S_GRP_RD;
					end else begin
						state_q <= S_SF_RD0;
					end
				end
				S_GRP_RD: begin
					if (g_q < grp_lim) begin
						state_q <= S_GRP_CHK;
					end else begin
						state_q <= cand_q ? S_LIN_MUL : S_MISS;
					end
				end
				S_GRP_CHK: begin
					// The last group whose first state is not above this state wins.
					if (gr_state <= 13'(st_q)) begin
						cand_q     <= 1'b1;
						cand_st_q  <= gr_state;
						cand_fan_q <= gr_fan;
						cand_idx_q <= gr_index;
						g_q        <= g_q + GW'(1);
						state_q    <= S_GRP_RD;
					end else begin
						state_q <= cand_q ? S_LIN_MUL : S_MISS;
					end
				end
				S_LIN_MUL: begin
					prod_q  <= (13'(st_q) - cand_st_q) * cand_fan_q;
					state_q <= S_LIN_ADD;
				end
				S_LIN_ADD: begin
					t_q     <= LIN_W'(prod_q) + LIN_W'(cand_idx_q);
					last_q  <= LIN_W'(prod_q) + LIN_W'(cand_idx_q) + LIN_W'(cand_fan_q);
					state_q <= S_LIN_RD;
				end
				S_LIN_RD: begin
					if (t_q < last_q && 32'(t_q) < MAX_TR_L) begin
						state_q <= S_LIN_CHK;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_LIN_CHK: begin
					if (tr_word == w_q) begin
						done_q   <= 1'b1;
						result_q <= '{tr_dest, add_sum, ST_FOUND};
						if (is_walk_q) begin
							walk_q <= tr_dest;
						end
						state_q <= S_IDLE;
					end else begin
						t_q     <= t_q + LIN_W'(1);
						state_q <= S_LIN_RD;
					end
				end
				S_SF_RD0: begin
					state_q <= S_SF_RD1;
				end
				S_SF_RD1: begin
					lo_q    <= sf_rdata;
					state_q <= S_SF_CHK;
				end
				S_SF_CHK: begin
					hi_q    <= sf_rdata;
					state_q <= S_BIN_RD;
				end
				S_BIN_RD: begin
					if (lo_q < hi_q && 32'(mid_c) < MAX_TR_L) begin
						mid_q   <= mid_c;
						state_q <= S_BIN_CHK;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_BIN_CHK: begin
					if (tr_word == w_q) begin
						done_q   <= 1'b1;
						result_q <= '{tr_dest, add_sum, ST_FOUND};
						if (is_walk_q) begin
							walk_q <= tr_dest;
						end
						state_q <= S_IDLE;
					end else begin
						if (tr_word < w_q) begin
							lo_q <= mid_q[16:0] + 17'd1;
						end else begin
							hi_q <= mid_q[16:0];
						end
						state_q <= S_BIN_RD;
					end
				end
				S_MISS: begin
					if (st_q == lowest_q) begin
						done_q   <= 1'b1;
						result_q <= '{lowest_q, SCORE_MIN, ST_NOT_FOUND};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_BO_RD;
					end
				end
				S_BO_RD: begin
					state_q <= S_BO_CHK;
				end
				S_BO_CHK: begin
					accum_q  <= add_sum;
					st_q     <= bo_d;
					visits_q <= visits_q + VW'(1);
					state_q  <= S_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/nbtl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/nbtl_checker.sv */
// Port-level checker for the n-gram backoff lookup, bound to the top level.
// Depends on nbtl_pkg and the assertion macros header.
`include "ngram_backoff_transition_lookup_defines.svh"

module nbtl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input nbtl_pkg::item_t   item,
	input logic              done,
	input nbtl_pkg::result_t result
);
	import nbtl_pkg::*;

	logic wr_cmd;
	assign wr_cmd = (item.cmd == CMD_WR_TRAN) || (item.cmd == CMD_WR_GRP) ||
		(item.cmd == CMD_WR_FIRST) || (item.cmd == CMD_WR_BO) ||
		(item.cmd == CMD_RSVD6) || (item.cmd == CMD_RSVD7);

	`NBTL_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result word while busy")
	`NBTL_ASSERT_NEXT(a_write_ack, clk, arst_n, start && !busy && wr_cmd, done && result.status == ST_WRITE_ACK, "write not acknowledged")
	`NBTL_ASSERT(a_miss_score, clk, arst_n, done && result.status == ST_NOT_FOUND |-> result.result_score == SCORE_MIN, "miss without zero probability")
	`NBTL_ASSERT(a_status_code, clk, arst_n, done |-> result.status != ST_UNUSED, "unused status code")

endmodule

bind ngram_backoff_transition_lookup nbtl_checker u_nbtl_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
	.done(done), .result(result)
);
